/* hw/rtl/ostb_pkg.sv */
package ostb_pkg;

    localparam int CMD_W   = 2;
    localparam int SLOT_FW = 4;
    localparam int DELAY_W = 31;

    localparam logic [CMD_W-1:0] OP_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] OP_ARM    = 2'd1;
    localparam logic [CMD_W-1:0] OP_CANCEL = 2'd2;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [SLOT_FW-1:0] slot;
        logic [DELAY_W-1:0] delay;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } chan_t;

endpackage

/* hw/rtl/ostb_if.sv */
interface ostb_req_if
    import ostb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_FW-1:0] slot;
    logic [DELAY_W-1:0] delay_ms;

    modport source (output valid, output cmd, output slot, output delay_ms, input ready);
    modport sink   (input valid, input cmd, input slot, input delay_ms, output ready);
endinterface

interface ostb_rsp_if
    import ostb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               fired;
    logic [SLOT_FW-1:0] fired_slot;
    logic               last;

    modport source (output valid, output fired, output fired_slot, output last, input ready);
    modport sink   (input valid, input fired, input fired_slot, input last, output ready);
endinterface

/* hw/rtl/ostb_front.sv */
module ostb_front
    import ostb_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    ostb_req_if.sink    req,
    input  logic        q_full,
    output chan_t       push
);

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t stage_item_reg;
    logic  accept;
    logic  keep;

    // unused commands and out-of-range slots are taken and dropped here
    always_comb
    begin
        keep = 1'b0;
        case (req.cmd)
            OP_TICK:   keep = 1'b1;
            OP_ARM:    keep = (32'(req.slot) < NUM_SLOTS);
            OP_CANCEL: keep = (32'(req.slot) < NUM_SLOTS);
            default:   keep = 1'b0;
        endcase
    end

    assign req.ready = !stage_valid_reg || !q_full;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = keep;
        end
        else if (!q_full)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg.op    <= req.cmd;
            stage_item_reg.slot  <= req.slot;
            stage_item_reg.delay <= req.delay_ms;
        end
    end

    assign push.valid = stage_valid_reg;
    assign push.item  = stage_item_reg;

endmodule

/* hw/rtl/ostb_queue.sv */
module ostb_queue
    import ostb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  chan_t push,
    output logic  full,
    input  logic  pop,
    output chan_t head
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    item_t            store [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QDEPTH));
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.item  = store[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push.item;
        end
    end

endmodule

/* hw/rtl/ostb_back.sv */
module ostb_back
    import ostb_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  chan_t       head,
    output logic        pop,
    ostb_rsp_if.source  rsp
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CMP_W  = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] now_next;
    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] active_next;
    logic [SLOT_W-1:0]    cmp_idx_reg;
    logic [SLOT_W-1:0]    cmp_idx_next;
    logic [SLOT_W-1:0]    pend_idx_reg;
    logic [SLOT_W-1:0]    pend_idx_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;

    logic [TIME_BITS-1:0] start_mem [NUM_SLOTS];
    logic [DELAY_W-1:0]   delay_mem [NUM_SLOTS];
    logic [TIME_BITS-1:0] start_q;
    logic [DELAY_W-1:0]   delay_q;
    logic                 mem_we;
    logic                 rd_en;
    logic [SLOT_W-1:0]    rd_addr;
    logic [SLOT_W-1:0]    op_slot;

    logic [TIME_BITS-1:0] elapsed;
    logic                 fire;
    logic                 out_free;
    logic                 emit;
    logic                 emit_fired;
    logic                 emit_last;
    logic [SLOT_W-1:0]    emit_idx;

    logic                 out_valid_reg;
    logic                 out_fired_reg;
    logic [SLOT_FW-1:0]   out_slot_reg;
    logic                 out_last_reg;

    assign op_slot  = SLOT_W'(head.item.slot);
    assign elapsed  = now_reg - start_q;
    assign fire     = active_reg[cmp_idx_reg] && (CMP_W'(elapsed) > CMP_W'(delay_q));
    assign out_free = !out_valid_reg || rsp.ready;

    // a fired slot is held as pending until the next one fires or the scan ends, so the final report can carry last
    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        active_next     = active_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_idx_next   = pend_idx_reg;
        pend_valid_next = pend_valid_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        emit            = 1'b0;
        emit_fired      = 1'b0;
        emit_last       = 1'b0;
        emit_idx        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.item.op)
                        OP_ARM:
                        begin
                            mem_we               = 1'b1;
                            active_next[op_slot] = 1'b1;
                        end
                        OP_CANCEL:
                        begin
                            active_next[op_slot] = 1'b0;
                        end
                        OP_TICK:
                        begin
                            now_next     = now_reg + 1'b1;
                            rd_en        = 1'b1;
                            rd_addr      = '0;
                            cmp_idx_next = '0;
                            state_next   = S_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!(fire && pend_valid_reg && !out_free))
                begin
                    if (fire)
                    begin
                        active_next[cmp_idx_reg] = 1'b0;
                        pend_valid_next          = 1'b1;
                        pend_idx_next            = cmp_idx_reg;
                        if (pend_valid_reg)
                        begin
                            emit       = 1'b1;
                            emit_fired = 1'b1;
                            emit_idx   = pend_idx_reg;
                        end
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmp_idx_next = cmp_idx_reg + 1'b1;
                        rd_en        = 1'b1;
                        rd_addr      = cmp_idx_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    emit_fired      = pend_valid_reg;
                    emit_idx        = pend_valid_reg ? pend_idx_reg : '0;
                    emit_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            active_reg     <= '0;
            cmp_idx_reg    <= '0;
            pend_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            active_reg     <= active_next;
            cmp_idx_reg    <= cmp_idx_next;
            pend_idx_reg   <= pend_idx_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_fired_reg <= emit_fired;
            out_slot_reg  <= SLOT_FW'(emit_idx);
            out_last_reg  <= emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            start_mem[op_slot] <= now_reg;
            delay_mem[op_slot] <= head.item.delay;
        end
        if (rd_en)
        begin
            start_q <= start_mem[rd_addr];
            delay_q <= delay_mem[rd_addr];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.fired      = out_fired_reg;
    assign rsp.fired_slot = out_slot_reg;
    assign rsp.last       = out_last_reg;

`ifndef SYNTHESIS
    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_fired_reg) |-> (out_last_reg && out_slot_reg == '0))
        else $error("empty tick word not marked last");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending report left over after scan");

    a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.item.op == OP_TICK) |=> (state_reg == S_SCAN && cmp_idx_reg == '0))
        else $error("tick did not start scan at slot zero");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.item.op == OP_TICK) |=> (now_reg == $past(now_reg) + 1'b1))
        else $error("millisecond count not advanced on tick");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !pop)
        else $error("queue popped while busy");
`endif

endmodule

/* hw/rtl/one_shot_timer_bank.sv */
// an arm or cancel word passes the front stage and the queue, then the back end applies it
// a tick word gives its last result after the back end has scanned all NUM_SLOTS slots
// a tick holds the back end for its whole scan (one slot read per cycle while no report stalls)
// the back end applies arm and cancel when idle; a 2-word queue decouples the input side
// reset: millisecond count zero, all slots inactive; slot start/delay stores are not cleared
module one_shot_timer_bank
    import ostb_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    ostb_req_if.sink    req,
    ostb_rsp_if.source  rsp
);

    chan_t push;
    chan_t head;
    logic  q_full;
    logic  pop;

    ostb_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_full (q_full),
        .push   (push)
    );

    ostb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (pop),
        .head  (head)
    );

    ostb_back #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule
